// File: hdl/aclasm_pkg.sv
// ----------------------------------------------------------------------------
// aclasm_pkg
// Shared types and character constants for the command line assembler.
// ----------------------------------------------------------------------------
package aclasm_pkg;

    // Character classes
    localparam logic [7:0] KEEP_LOW   = 8'd31;   // kept bytes lie above this
    localparam logic [7:0] KEEP_HIGH  = 8'd127;  // and below this
    localparam logic [7:0] UPPER_LOW  = 8'd64;   // upper case lies above this
    localparam logic [7:0] UPPER_HIGH = 8'd91;   // and below this
    localparam logic [7:0] CASE_STEP  = 8'd32;   // upper to lower case offset
    localparam logic [7:0] DOT_CHAR   = 8'h2E;   // '.'
    localparam logic [7:0] NUL_CHAR   = 8'h00;

    // Controller states, one-hot
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_SEND = 3'b100
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // input beat taken this cycle
        logic rd;       // read line store at current position
        logic step;     // output beat taken, advance position
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic line_end; // current input byte closes the line
        logic last_pos; // position is the final one of the line
    } sts_t;

endpackage

// File: hdl/aclasm_ctrl.sv
// ----------------------------------------------------------------------------
// aclasm_ctrl
// Sequencer: takes bytes while idle, then reads out the line one beat at a
// time (store read, then output beat).
// ----------------------------------------------------------------------------
module aclasm_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rx_valid,
    output logic              rx_stall,
    output logic              line_valid,
    input  logic              line_stall,
    input  aclasm_pkg::sts_t  sts,
    output aclasm_pkg::cmd_t  cmd
);
    import aclasm_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        rx_stall   = 1'b1;
        line_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                rx_stall   = 1'b0;
                cmd.accept = rx_valid;
                if (rx_valid && sts.line_end)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_SEND;
            end
            S_SEND:
            begin
                line_valid = 1'b1;
                if (!line_stall)
                begin
                    cmd.step   = 1'b1;
                    state_next = sts.last_pos ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/aclasm_dp.sv
// ----------------------------------------------------------------------------
// aclasm_dp
// Datapath: byte filter and case fold, line store, fill count and readout
// position.
// ----------------------------------------------------------------------------
module aclasm_dp
#(
    parameter int LINE_LEN = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        rx_byte,
    input  aclasm_pkg::cmd_t  cmd,
    output aclasm_pkg::sts_t  sts,
    output logic [7:0]        line_char,
    output logic              line_last
);
    import aclasm_pkg::*;

    localparam int ADDR_W = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;
    localparam int CNT_W  = $clog2(LINE_LEN + 1);

    logic [7:0]        store_mem [LINE_LEN];
    logic [7:0]        rd_data_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    logic [ADDR_W-1:0] pos_reg;
    logic [ADDR_W-1:0] pos_next;

    logic              keep;
    logic              upper;
    logic [7:0]        folded;
    logic              is_last_slot;

    // Byte classification and case fold
    assign keep   = (rx_byte > KEEP_LOW) && (rx_byte < KEEP_HIGH);
    assign upper  = (rx_byte > UPPER_LOW) && (rx_byte < UPPER_HIGH);
    assign folded = upper ? (rx_byte + CASE_STEP) : rx_byte;

    // Fill count is always below LINE_LEN while bytes are taken
    assign is_last_slot = (fill_reg == CNT_W'(LINE_LEN - 1));

    assign sts.line_end = (keep && (is_last_slot || folded == DOT_CHAR))
                          || (rx_byte == NUL_CHAR);
    assign sts.last_pos = (pos_reg == ADDR_W'(LINE_LEN - 1));

    // Counters
    always_comb
    begin
        fill_next = fill_reg;
        pos_next  = pos_reg;
        if (cmd.accept && keep)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        if (cmd.step)
        begin
            if (sts.last_pos)
            begin
                pos_next  = '0;
                fill_next = '0;
            end
            else
            begin
                pos_next = pos_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            pos_reg  <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            pos_reg  <= pos_next;
        end
    end

    // Line store: write on kept byte, registered read at readout position
    always_ff @(posedge clk)
    begin
        if (cmd.accept && keep)
        begin
            store_mem[fill_reg[ADDR_W-1:0]] <= folded;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= store_mem[pos_reg];
        end
    end

    // Output beat: stored byte or zero padding
    assign line_char = (CNT_W'(pos_reg) < fill_reg) ? rd_data_reg : 8'd0;
    assign line_last = sts.last_pos;

endmodule

// File: hdl/ascii_command_line_assembler_unit.sv
// ----------------------------------------------------------------------------
// ascii_command_line_assembler_unit
// Collects printable bytes (upper case folded to lower) into a line and,
// at a line end, sends the whole line padded with zeros to LINE_LEN bytes.
//
//   channel | direction | handshake             | payload
//   rx      | in        | rx_valid / rx_stall   | rx_byte
//   line    | out       | line_valid / line_stall | line_char, line_last
//
// A byte that does not end a line is taken without stalling the input.
// A line end is followed by LINE_LEN beats, each a store read and then an output beat.
// No input is taken during readout; rx_stall is high from the line end
// through the cycle of the last beat.
// Reset clears the fill count, readout position and sequencer; the line
// store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module ascii_command_line_assembler_unit
#(
    parameter int LINE_LEN = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    output logic       line_valid,
    input  logic       line_stall,
    output logic [7:0] line_char,
    output logic       line_last
);
    import aclasm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    aclasm_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_stall   (rx_stall),
        .line_valid (line_valid),
        .line_stall (line_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    aclasm_dp
    #(
        .LINE_LEN (LINE_LEN)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_byte    (rx_byte),
        .cmd        (cmd),
        .sts        (sts),
        .line_char  (line_char),
        .line_last  (line_last)
    );

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the command line assembler. A short table of
// directed bytes is followed by random line traffic: full lines, lines closed
// by a dot or a zero byte, and dropped noise. Every accepted input beat runs
// through a line predictor. Every output beat is compared with the oldest
// predicted beat. Both channels idle and stall at random, with one long sink
// hold-off and one sender pause that lets the line queue drain.
// ----------------------------------------------------------------------------
module testbench;

    import aclasm_pkg::*;

    localparam int LINE_LEN       = 32;
    localparam int RANDOM_ITEMS   = 300;
    localparam int MAX_GAP        = 6;
    localparam int SINK_HOLD      = 400;
    // Longest quiet stretch of a clean run is the sink hold-off plus one
    // stalled readout beat; the limit is several times that.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS    = 10;

    // How a directed row is checked
    typedef enum logic [1:0] {
        ROW_MODEL,  // checked against the predictor
        ROW_BLANK,  // typed in: LINE_LEN zero beats, last one marked
        ROW_SILENT  // typed in: no beat at all
    } row_kind_t;

    typedef struct packed {
        logic [7:0] raw;
        row_kind_t  kind;
    } dir_row_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } line_beat_t;

    logic       clk;
    logic       rst_n      = 1'b0;
    logic       rx_valid   = 1'b0;
    logic       rx_stall;
    logic [7:0] rx_byte    = 8'h00;
    logic       line_valid;
    logic       line_stall = 1'b1;
    logic [7:0] line_char;
    logic       line_last;

    // Shared between stimulus, sink and monitor
    bit         quiet_mode    = 1'b0;
    bit         sink_hold_req = 1'b0;
    int         fail_count    = 0;

    // Predictor state
    logic [7:0] line_buf [LINE_LEN];
    int         line_fill = 0;
    line_beat_t assembled_line [$];

    line_beat_t line_beats_due [$];
    row_kind_t  rx_row_kinds [$];

    // Directed bytes: reset case, range edges, case folding, line closers
    localparam int DIR_ROWS = 21;
    dir_row_t directed_rows [DIR_ROWS] = '{
        '{NUL_CHAR, ROW_BLANK},   // zero byte on an empty line
        '{8'h01,    ROW_SILENT},
        '{8'h1F,    ROW_SILENT},
        '{8'h7F,    ROW_SILENT},
        '{8'h80,    ROW_SILENT},
        '{8'hFF,    ROW_SILENT},
        '{NUL_CHAR, ROW_BLANK},   // dropped bytes left the line empty
        '{8'h20,    ROW_MODEL},   // lowest kept byte
        '{8'h7E,    ROW_MODEL},   // highest kept byte
        '{8'h40,    ROW_MODEL},   // just below upper case
        '{8'h41,    ROW_MODEL},
        '{8'h5A,    ROW_MODEL},
        '{8'h5B,    ROW_MODEL},   // just above upper case
        '{8'h61,    ROW_MODEL},
        '{DOT_CHAR, ROW_MODEL},   // dot is stored and closes the line
        '{DOT_CHAR, ROW_MODEL},   // line of a single dot
        '{8'h7A,    ROW_MODEL},
        '{NUL_CHAR, ROW_MODEL},   // zero closes without being stored
        '{8'h60,    ROW_MODEL},
        '{8'h0A,    ROW_SILENT},
        '{NUL_CHAR, ROW_MODEL}
    };

    ascii_command_line_assembler_unit #(
        .LINE_LEN (LINE_LEN)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_stall   (rx_stall),
        .rx_byte    (rx_byte),
        .line_valid (line_valid),
        .line_stall (line_stall),
        .line_char  (line_char),
        .line_last  (line_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Line predictor: folds and stores one byte, fills assembled_line on a line end
    function automatic void assemble_byte(input logic [7:0] raw);
        logic [7:0] ch;
        bit         done;
        ch   = raw;
        done = 1'b0;
        assembled_line.delete();
        if (raw > KEEP_LOW && raw < KEEP_HIGH)
        begin
            if (ch > UPPER_LOW && ch < UPPER_HIGH)
                ch = ch + CASE_STEP;
            if (line_fill < LINE_LEN)
            begin
                line_buf[line_fill] = ch;
                line_fill++;
            end
            if (line_fill >= LINE_LEN || ch == DOT_CHAR)
                done = 1'b1;
        end
        else if (raw == NUL_CHAR)
        begin
            done = 1'b1;
        end
        if (done)
        begin
            for (int i = 0; i < LINE_LEN; i++)
                assembled_line.push_back('{(i < line_fill) ? line_buf[i] : 8'h00,
                                           i == LINE_LEN - 1});
            line_fill = 0;
        end
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] %s", $realtime, msg);
    endtask

    // Monitor: check output beats first, then predict from the input beat
    always @(posedge clk)
    begin : line_monitor
        line_beat_t want;
        row_kind_t  kind;
        if (rst_n)
        begin
            if (line_valid && !line_stall)
            begin
                if (line_beats_due.size() == 0)
                    note_failure($sformatf("unexpected beat: char=%02h last=%b",
                                           line_char, line_last));
                else
                begin
                    want = line_beats_due.pop_front();
                    if (line_char !== want.ch || line_last !== want.last)
                        note_failure($sformatf(
                            "beat mismatch: expected char=%02h last=%b, got char=%02h last=%b",
                            want.ch, want.last, line_char, line_last));
                end
            end
            if (rx_valid && !rx_stall)
            begin
                kind = (rx_row_kinds.size() != 0) ? rx_row_kinds.pop_front() : ROW_MODEL;
                assemble_byte(rx_byte);
                case (kind)
                    ROW_MODEL:
                        foreach (assembled_line[i])
                            line_beats_due.push_back(assembled_line[i]);
                    ROW_BLANK:
                        for (int i = 0; i < LINE_LEN; i++)
                            line_beats_due.push_back('{8'h00, i == LINE_LEN - 1});
                    default:
                        ;
                endcase
            end
        end
    end

    // Sink: random stall per beat, plus one long hold-off on request
    initial
    begin : line_sink
        int wait_cycles;
        @(posedge rst_n);
        forever
        begin
            if (sink_hold_req)
            begin
                sink_hold_req = 1'b0;
                line_stall <= 1'b1;
                repeat (SINK_HOLD) @(posedge clk);
            end
            wait_cycles = quiet_mode ? 0 : $urandom_range(0, MAX_GAP);
            if (wait_cycles > 0)
            begin
                line_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            line_stall <= 1'b0;
            do
                @(posedge clk);
            while (!line_valid);
        end
    end

    // Watchdog: ends the run when no beat moves for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((rx_valid && !rx_stall) || (line_valid && !line_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // Offer one byte after a random gap, none in quiet mode; returns at the edge it is taken
    task automatic offer_rx_byte(input logic [7:0] raw, input row_kind_t kind);
        int gap;
        gap = quiet_mode ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_row_kinds.push_back(kind);
        rx_valid <= 1'b1;
        rx_byte  <= raw;
        do
            @(posedge clk);
        while (rx_stall);
    endtask

    function automatic logic [7:0] pick_printable(input bit no_dot);
        logic [7:0] c;
        do
            c = 8'($urandom_range(32, 126));
        while (no_dot && c == DOT_CHAR);
        return c;
    endfunction

    function automatic logic [7:0] pick_dropped();
        if ($urandom_range(0, 1) != 0)
            return 8'($urandom_range(1, 31));
        return 8'($urandom_range(127, 255));
    endfunction

    // Stimulus and end of run
    initial
    begin : stimulus
        int         item_count;
        int         line_no;
        int         plan;
        int         len;
        logic [7:0] raw;
        item_count = 0;
        line_no    = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer_rx_byte(directed_rows[i].raw, directed_rows[i].kind);

        // Random lines; dropped bytes do not count toward the item total
        while (item_count < RANDOM_ITEMS)
        begin
            plan       = $urandom_range(0, 9);
            quiet_mode = ($urandom_range(0, 4) == 0);
            if (line_no == 3)
            begin
                // long sink hold-off while a full line is offered
                sink_hold_req = 1'b1;
                plan = 0;
            end
            if (line_no == 8)
            begin
                // let every pending line drain before going on
                rx_valid <= 1'b0;
                do
                    @(posedge clk);
                while (line_beats_due.size() != 0);
            end
            case (plan)
                0, 1:
                begin
                    for (int k = 0; k < LINE_LEN; k++)
                    begin
                        if ($urandom_range(0, 7) == 0)
                            offer_rx_byte(pick_dropped(), ROW_MODEL);
                        offer_rx_byte(pick_printable(1'b1), ROW_MODEL);
                        item_count++;
                    end
                end
                2, 3, 4, 5:
                begin
                    len = $urandom_range(0, 12);
                    for (int k = 0; k < len; k++)
                    begin
                        offer_rx_byte(pick_printable(1'b1), ROW_MODEL);
                        item_count++;
                    end
                    offer_rx_byte(DOT_CHAR, ROW_MODEL);
                    item_count++;
                end
                6, 7:
                begin
                    len = $urandom_range(0, 12);
                    for (int k = 0; k < len; k++)
                    begin
                        offer_rx_byte(pick_printable(1'b0), ROW_MODEL);
                        item_count++;
                    end
                    offer_rx_byte(NUL_CHAR, ROW_MODEL);
                    item_count++;
                end
                8:
                begin
                    len = $urandom_range(1, 6);
                    for (int k = 0; k < len; k++)
                    begin
                        raw = 8'($urandom_range(0, 255));
                        offer_rx_byte(raw, ROW_MODEL);
                        if (raw == NUL_CHAR || (raw > KEEP_LOW && raw < KEEP_HIGH))
                            item_count++;
                    end
                end
                default:
                begin
                    // open line carried into the next plan
                    len = $urandom_range(1, 10);
                    for (int k = 0; k < len; k++)
                    begin
                        if ($urandom_range(0, 3) == 0)
                            offer_rx_byte(pick_dropped(), ROW_MODEL);
                        offer_rx_byte(pick_printable(1'b1), ROW_MODEL);
                        item_count++;
                    end
                end
            endcase
            line_no++;
        end

        // Close any open line, then drain
        offer_rx_byte(NUL_CHAR, ROW_MODEL);
        rx_valid   <= 1'b0;
        quiet_mode  = 1'b0;
        do
            @(posedge clk);
        while (line_beats_due.size() != 0);
        repeat (2 * LINE_LEN + 8) @(posedge clk);

        if (line_beats_due.size() != 0)
            note_failure($sformatf("%0d expected beats never came",
                                   line_beats_due.size()));
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
